// ===== src/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types, constants and the cumulative month table for the calendar
// day difference core.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 23;
  localparam int COUNT_W  = 22;

  // reciprocal of 100 in q19, exact for operands below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  YEARS_PER_CENTURY = 7'd100;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [MONTH_W-1:0] IDX_FEB     = 4'd1;

  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = 22'd4194303;

  typedef logic [SERIAL_W-1:0] serial_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // days before the first of each month in a common year, index 0 is january
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/cdd_serial.sv =====
// ----------------------------------------------------------------------------
// cdd_serial
// Three-stage conversion of one date into a serial day number: products,
// then quotients and month offset, then the final sum.
// ----------------------------------------------------------------------------
module cdd_serial
  import cdd_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  date_t   date,
  output serial_t serial
);

  // stage 1 registers
  logic [YEAR_W-1:0]  s1_y;
  logic [MONTH_W-1:0] s1_midx;
  logic [DAY_W-1:0]   s1_d;
  logic [22:0]        s1_yp365;
  logic [12:0]        s1_q4;
  logic [27:0]        s1_p100;
  logic [25:0]        s1_p400;
  logic [26:0]        s1_py;

  // stage 2 registers
  logic [22:0]        s2_a;
  logic [7:0]         s2_c;
  logic [9:0]         s2_m;

  logic [MONTH_W-1:0] midx;
  logic [14:0]        y99;
  logic [14:0]        y399;
  logic [14:0]        y3;

  // clamp month to january..december and turn it into a table index
  always_comb begin
    if (date.month < MONTH_FIRST) begin
      midx = 4'd0;
    end else if (date.month > MONTH_LAST) begin
      midx = MONTH_LAST - MONTH_FIRST;
    end else begin
      midx = date.month - MONTH_FIRST;
    end
  end

  assign y99  = 15'(date.year) + 15'd99;
  assign y399 = 15'(date.year) + 15'd399;
  assign y3   = 15'(date.year) + 15'd3;

  // stage 1: year times 365, the quarter term and reciprocal products for the century terms
  always_ff @(posedge clk) begin
    if (en) begin
      s1_y     <= date.year;
      s1_midx  <= midx;
      s1_d     <= date.day;
      s1_yp365 <= 23'(23'(date.year) * 23'(DAYS_PER_YEAR));
      s1_q4    <= 13'(y3 >> 2);
      s1_p100  <= 28'(28'(y99) * 28'(RECIP_100));
      s1_p400  <= 26'(26'(y399[14:2]) * 26'(RECIP_100));
      s1_py    <= 27'(27'(date.year) * 27'(RECIP_100));
    end
  end

  logic [7:0]  q100;
  logic [5:0]  q400;
  logic [7:0]  qy;
  logic        div100;
  logic        leap;
  logic [9:0]  mpart;

  // quotients, leap test and offset inside the year
  always_comb begin
    q100   = 8'(s1_p100 >> RECIP_SHIFT);
    q400   = 6'(s1_p400 >> RECIP_SHIFT);
    qy     = 8'(s1_py >> RECIP_SHIFT);
    div100 = (s1_y == 14'(14'(qy) * 14'(YEARS_PER_CENTURY)));
    leap   = ((s1_y[1:0] == 2'd0) && !div100) || (div100 && (qy[1:0] == 2'd0));
    mpart  = 10'(days_before_month(s1_midx))
           + 10'(leap && (s1_midx > IDX_FEB))
           + 10'(s1_d);
  end

  // stage 2: gather the positive year terms
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a <= s1_yp365 + 23'(s1_q4) + 23'(q400);
      s2_c <= q100;
      s2_m <= mpart;
    end
  end

  // stage 3: final serial
  always_ff @(posedge clk) begin
    if (en) begin
      serial <= s2_a - 23'(s2_c) + 23'(s2_m);
    end
  end

endmodule

// ===== src/cdd_diff.sv =====
// ----------------------------------------------------------------------------
// cdd_diff
// Two-stage absolute difference of two serial day numbers with saturation
// to the result width.
// ----------------------------------------------------------------------------
module cdd_diff
  import cdd_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  serial_t            serial_a,
  input  serial_t            serial_b,
  output logic [COUNT_W-1:0] day_count
);

  serial_t diff;

  // stage 4: absolute difference
  always_ff @(posedge clk) begin
    if (en) begin
      diff <= (serial_a > serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
    end
  end

  // stage 5: saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      day_count <= (diff > SERIAL_W'(DAY_COUNT_MAX)) ? DAY_COUNT_MAX : diff[COUNT_W-1:0];
    end
  end

endmodule

// ===== src/calendar_day_difference_core.sv =====
// ----------------------------------------------------------------------------
// calendar_day_difference_core
// Days between two gregorian dates, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   An input transaction carries two dates as year, month and day fields.
//   It is taken at a rising edge with item_valid high and item_stall low.
//   A result transaction carries day_count, the absolute number of days
//   between the dates, and completes with result_valid high and
//   result_stall low.
//   Five register stages: three turn each date into a serial day number
//   (two converters in parallel), two more take the difference and
//   saturate it. The first stage loads at the accepting edge, and each
//   advance moves the transaction on until it reaches day_count.
//   Throughput is one transaction per cycle while no result is held.
//   While a result is held by result_stall the whole pipeline freezes and
//   item_stall is raised, so nothing is lost or repeated.
//   Synchronous reset clears all valid bits; the data path needs no reset.
// ----------------------------------------------------------------------------
module calendar_day_difference_core
  import cdd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [YEAR_W-1:0]  first_year,
  input  logic [MONTH_W-1:0] first_month,
  input  logic [DAY_W-1:0]   first_day,
  input  logic [YEAR_W-1:0]  second_year,
  input  logic [MONTH_W-1:0] second_month,
  input  logic [DAY_W-1:0]   second_day,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COUNT_W-1:0] day_count
);

  localparam int DEPTH = 5;

  logic            advance;
  logic [DEPTH-1:0] valid_pipe;
  date_t           date_a;
  date_t           date_b;
  serial_t         serial_a;
  serial_t         serial_b;

  // pipeline moves unless a finished result is being held
  assign advance      = !(result_valid && result_stall);
  assign item_stall   = !advance;
  assign result_valid = valid_pipe[DEPTH-1];

  assign date_a = '{year: first_year, month: first_month, day: first_day};
  assign date_b = '{year: second_year, month: second_month, day: second_day};

  // valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (advance) begin
      valid_pipe <= {valid_pipe[DEPTH-2:0], item_valid};
    end
  end

  cdd_serial u_serial_a (
    .clk    (clk),
    .en     (advance),
    .date   (date_a),
    .serial (serial_a)
  );

  cdd_serial u_serial_b (
    .clk    (clk),
    .en     (advance),
    .date   (date_b),
    .serial (serial_b)
  );

  cdd_diff u_diff (
    .clk       (clk),
    .en        (advance),
    .serial_a  (serial_a),
    .serial_b  (serial_b),
    .day_count (day_count)
  );

  // reset leaves no result pending
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result_valid set right after reset");

  // an accepted transaction reaches the output once the pipeline has advanced through every stage
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) ##1 !item_stall ##1 !item_stall ##1 !item_stall
      ##1 !item_stall |=> result_valid)
    else $error("accepted transaction did not arrive at the output");

  // identical dates give a zero count
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && first_year == second_year
      && first_month == second_month && first_day == second_day)
      ##1 !item_stall ##1 !item_stall ##1 !item_stall ##1 !item_stall
      |=> (day_count == '0))
    else $error("equal dates gave a nonzero count");

  // a new result only appears on a cycle the pipeline advanced
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance))
    else $error("result appeared while the pipeline was frozen");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for calendar_day_difference_core. Drives pairs of dates through
// the valid/stall input channel and predicts each day count by turning both
// dates into serial day numbers. Covers directed corner dates, random valid
// and raw field values, a long result hold-off and back-to-back streaming.
// ----------------------------------------------------------------------------
module tb;
  import cdd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 150;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [YEAR_W-1:0]  first_year;
  logic [MONTH_W-1:0] first_month;
  logic [DAY_W-1:0]   first_day;
  logic [YEAR_W-1:0]  second_year;
  logic [MONTH_W-1:0] second_month;
  logic [DAY_W-1:0]   second_day;
  logic               result_valid;
  logic               result_stall;
  logic [COUNT_W-1:0] day_count;

  // day counts still owed by the core, oldest first
  logic [COUNT_W-1:0] pending_counts [$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  send_gaps;
  bit  recv_gaps;
  int  hold_request;

  calendar_day_difference_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .first_year   (first_year),
    .first_month  (first_month),
    .first_day    (first_day),
    .second_year  (second_year),
    .second_month (second_month),
    .second_day   (second_day),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .day_count    (day_count)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gregorian leap rule
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    case (m)
      2:          return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // serial day number, year 0 counted as leap; month clamped to 1..12
  function automatic int unsigned serial_of(input logic [YEAR_W-1:0] year,
                                            input logic [MONTH_W-1:0] month,
                                            input logic [DAY_W-1:0] day);
    int unsigned y;
    int unsigned m;
    int unsigned s;
    y = 32'(year);
    m = 32'(month);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    s = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) s += month_len(k, y);
    s += 32'(day);
    return s;
  endfunction

  // absolute difference of the two serials, saturated to the output width
  function automatic logic [COUNT_W-1:0] calc_day_count(
      input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1, input logic [DAY_W-1:0] d1,
      input logic [YEAR_W-1:0] y2, input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
    int unsigned a;
    int unsigned b;
    int unsigned diff;
    a = serial_of(y1, m1, d1);
    b = serial_of(y2, m2, d2);
    diff = (a > b) ? a - b : b - a;
    if (diff > 32'(DAY_COUNT_MAX)) diff = 32'(DAY_COUNT_MAX);
    return diff[COUNT_W-1:0];
  endfunction

  // offer one transaction and wait until the core takes it
  task automatic send_dates(input int y1, input int m1, input int d1,
                            input int y2, input int m2, input int d2);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   = 1'b1;
    first_year   = YEAR_W'(y1);
    first_month  = MONTH_W'(m1);
    first_day    = DAY_W'(d1);
    second_year  = YEAR_W'(y2);
    second_month = MONTH_W'(m2);
    second_day   = DAY_W'(d2);
    do @(posedge clk); while (item_stall);
    pending_counts.push_back(calc_day_count(first_year, first_month, first_day,
                                            second_year, second_month, second_day));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // a random date within 1..9999 that exists on the calendar
  task automatic pick_date(output int y, output int m, output int d);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_len(m, y));
  endtask

  task automatic send_random_pair();
    int y1, m1, d1, y2, m2, d2;
    int sel;
    sel = $urandom_range(0, 9);
    pick_date(y1, m1, d1);
    pick_date(y2, m2, d2);
    if (sel >= 6 && sel <= 7) begin
      // dates in the same or adjacent years, often straddling a year end
      y2 = y1 + $urandom_range(0, 1);
      if (y2 > 9999) y2 = 9999;
      d2 = $urandom_range(1, month_len(m2, y2));
    end else if (sel >= 8) begin
      // raw field values, out-of-range months, days and years included
      y1 = $urandom_range(0, 16383);
      m1 = $urandom_range(0, 15);
      d1 = $urandom_range(0, 31);
      y2 = $urandom_range(0, 16383);
      m2 = $urandom_range(0, 15);
      d2 = $urandom_range(0, 31);
    end
    send_dates(y1, m1, d1, y2, m2, d2);
  endtask

  // corner dates and the odd field values
  task automatic test_directed();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    send_dates(2024, 5, 17, 2024, 5, 17);    // equal dates
    send_dates(1, 1, 1, 9999, 12, 31);       // widest legal span
    send_dates(9999, 12, 31, 1, 1, 1);       // same span, reversed
    send_dates(2000, 2, 28, 2000, 3, 1);     // leap century
    send_dates(1900, 2, 28, 1900, 3, 1);     // non-leap century
    send_dates(2004, 2, 29, 2005, 3, 1);     // ordinary leap year
    send_dates(2023, 12, 31, 2024, 1, 1);    // year rollover
    send_dates(2023, 0, 10, 2023, 1, 10);    // month zero acts as january
    send_dates(2023, 13, 5, 2023, 12, 5);    // month above twelve acts as december
    send_dates(2023, 15, 31, 2022, 15, 31);
    send_dates(2023, 3, 0, 2023, 2, 28);     // day zero is end of previous month
    send_dates(2023, 2, 31, 2023, 3, 3);     // day past month end rolls over
    send_dates(2024, 4, 31, 2024, 5, 1);
    send_dates(0, 1, 1, 1, 1, 1);            // year zero, leap
    send_dates(0, 3, 1, 0, 2, 28);
    send_dates(16383, 15, 31, 0, 0, 0);      // saturates
    send_dates(0, 0, 0, 16383, 15, 31);
    send_dates(10000, 1, 1, 9999, 1, 1);     // year above 9999
    send_dates(9999, 12, 31, 9999, 12, 31);
    send_dates(1, 1, 1, 1, 1, 1);
  endtask

  task automatic test_random();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_random_pair();
  endtask

  // receiver holds off long enough that the pipeline backs up into the input
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 25; i++) send_random_pair();
  endtask

  // no idling on either side
  task automatic test_streaming();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int i = 0; i < 25; i++) send_random_pair();
  endtask

  // result side stall pattern
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = recv_gaps ? $urandom_range(0, 7) : 0;
      end
      @(negedge clk);
      if (n > 0) begin
        result_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid || rst);
    end
  end

  // compare each completed result transaction with the oldest prediction
  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected day_count, expected none actual %0d", $time, day_count);
        mismatches++;
      end else begin
        want = pending_counts.pop_front();
        if (day_count !== want) begin
          $display("%0t: day_count expected %0d actual %0d", $time, want, day_count);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    first_year   = '0;
    first_month  = '0;
    first_day    = '0;
    second_year  = '0;
    second_month = '0;
    second_day   = '0;
    send_gaps    = 1'b0;
    recv_gaps    = 1'b0;
    hold_request = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random();
    test_backpressure();
    test_streaming();
    stop_sending();

    // drain, then allow for anything extra the core might still emit
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
